// File: src/fac_pkg.sv
package fac_pkg;

   // default sizes of the block
   localparam int PRED_ORDER_DEF  = 12;
   localparam int MAX_FRAME_DEF   = 512;
   localparam int SAMPLE_BITS_DEF = 16;

   // fixed widths of the result fields
   localparam int LAG_W = 4;
   localparam int SUM_W = 41;

   // control that travels with an item down the pipeline
   typedef struct packed {
      logic valid;
      logic last;
   } ctl_type;

endpackage

// File: src/fac_front.sv
module fac_front #(
   parameter int PRED_ORDER  = fac_pkg::PRED_ORDER_DEF,
   parameter int SAMPLE_BITS = fac_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          req_valid,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_frame_end,
   output fac_pkg::ctl_type              prod_ctl,
   output logic signed [2*SAMPLE_BITS-1:0] prod [PRED_ORDER+1]
);
   import fac_pkg::*;

   localparam int PROD_W = 2 * SAMPLE_BITS;

   ctl_type                   s1_ctl_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   ctl_type                   s2_ctl_ff;
   logic signed [SAMPLE_BITS-1:0] past_ff [PRED_ORDER];
   logic signed [PROD_W-1:0]  prod_in [PRED_ORDER+1];
   logic signed [PROD_W-1:0]  prod_ff [PRED_ORDER+1];

   // one product per lag: the new sample against itself and each of the PRED_ORDER earlier samples of the frame
   always_comb begin
      prod_in[0] = s1_sample_ff * s1_sample_ff;
      for (int k = 1; k <= PRED_ORDER; k++) begin
         prod_in[k] = s1_sample_ff * past_ff[k-1];
      end
   end

   // pipeline control and delay line
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         for (int k = 0; k < PRED_ORDER; k++) begin
            past_ff[k] <= '0;
         end
      end else if (adv) begin
         s1_ctl_ff.valid <= req_valid;
         s1_ctl_ff.last  <= req_frame_end;
         s2_ctl_ff       <= s1_ctl_ff;
         if (s1_ctl_ff.valid) begin
            if (s1_ctl_ff.last) begin
               // frame done, start the next one from an empty delay line
               for (int k = 0; k < PRED_ORDER; k++) begin
                  past_ff[k] <= '0;
               end
            end else begin
               for (int k = PRED_ORDER - 1; k > 0; k--) begin
                  past_ff[k] <= past_ff[k-1];
               end
               past_ff[0] <= s1_sample_ff;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sample_ff <= req_sample;
         for (int k = 0; k <= PRED_ORDER; k++) begin
            prod_ff[k] <= prod_in[k];
         end
      end
   end

   assign prod_ctl = s2_ctl_ff;
   assign prod     = prod_ff;

endmodule

// File: src/fac_accum.sv
module fac_accum #(
   parameter int PRED_ORDER  = fac_pkg::PRED_ORDER_DEF,
   parameter int MAX_FRAME   = fac_pkg::MAX_FRAME_DEF,
   parameter int SAMPLE_BITS = fac_pkg::SAMPLE_BITS_DEF,
   parameter int ACC_W       = $clog2(MAX_FRAME) + 2 * SAMPLE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fac_pkg::ctl_type                prod_ctl,
   input  logic signed [2*SAMPLE_BITS-1:0] prod [PRED_ORDER+1],
   input  logic                            bank_free,
   output logic                            adv,
   output logic                            snap,
   output logic signed [ACC_W-1:0]         sums [PRED_ORDER+1]
);
   import fac_pkg::*;

   localparam logic signed [ACC_W:0] LIMIT =
      signed'((ACC_W+1)'(MAX_FRAME) << (2 * SAMPLE_BITS - 2));
   localparam logic signed [ACC_W:0] NEG_LIMIT = -LIMIT;

   logic signed [ACC_W-1:0] acc_ff [PRED_ORDER+1];
   logic signed [ACC_W:0]   raw [PRED_ORDER+1];

   // add each product and clamp to the saturation limit
   always_comb begin
      for (int k = 0; k <= PRED_ORDER; k++) begin
         raw[k] = (ACC_W+1)'(acc_ff[k]) + (ACC_W+1)'(prod[k]);
         if (raw[k] > LIMIT) begin
            sums[k] = ACC_W'(LIMIT);
         end else if (raw[k] < NEG_LIMIT) begin
            sums[k] = ACC_W'(NEG_LIMIT);
         end else begin
            sums[k] = ACC_W'(raw[k]);
         end
      end
   end

   // a frame end holds the pipeline until the output bank can take the sums
   assign adv  = !(prod_ctl.valid && prod_ctl.last && !bank_free);
   assign snap = prod_ctl.valid && prod_ctl.last && bank_free;

   // accumulators, cleared once the frame's sums go to the bank
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= PRED_ORDER; k++) begin
            acc_ff[k] <= '0;
         end
      end else if (prod_ctl.valid && adv) begin
         for (int k = 0; k <= PRED_ORDER; k++) begin
            acc_ff[k] <= prod_ctl.last ? '0 : sums[k];
         end
      end
   end

endmodule

// File: src/fac_drain.sv
module fac_drain #(
   parameter int PRED_ORDER = fac_pkg::PRED_ORDER_DEF,
   parameter int ACC_W      = fac_pkg::SUM_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        snap,
   input  logic signed [ACC_W-1:0]     sums [PRED_ORDER+1],
   output logic                        bank_free,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [fac_pkg::LAG_W-1:0]   rsp_lag,
   output logic signed [fac_pkg::SUM_W-1:0] rsp_corr_sum,
   output logic                        rsp_run_last
);
   import fac_pkg::*;

   localparam int CNT_W = (PRED_ORDER + 1 > 1) ? $clog2(PRED_ORDER + 1) : 1;
   localparam logic [CNT_W-1:0] LAST_LAG = CNT_W'(PRED_ORDER);

   logic signed [ACC_W-1:0] bank_ff [PRED_ORDER+1];
   logic                    busy_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    at_last;
   logic                    step;

   assign at_last   = (cnt_ff == LAST_LAG);
   assign step      = busy_ff && !rsp_stall;
   assign bank_free = !busy_ff || (step && at_last);

   // run state: busy while the bank still holds undelivered sums
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (snap) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (step) begin
         if (at_last) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // bank loads on a frame end and shifts toward the head as items leave
   always_ff @(posedge clock) begin
      if (snap) begin
         for (int k = 0; k <= PRED_ORDER; k++) begin
            bank_ff[k] <= sums[k];
         end
      end else if (step) begin
         for (int k = 0; k < PRED_ORDER; k++) begin
            bank_ff[k] <= bank_ff[k+1];
         end
      end
   end

   assign rsp_valid    = busy_ff;
   assign rsp_lag      = LAG_W'(cnt_ff);
   assign rsp_corr_sum = SUM_W'(bank_ff[0]);
   assign rsp_run_last = at_last;

endmodule

// File: src/frame_autocorrelation_unit.sv
// path: a frame end passes the input and product registers and then loads the bank
// throughput: one sample per cycle while no frame end waits, set by one multiplier
// per lag in the product stage; a frame's sums leave one per cycle unless rsp_stall
// is high, PRED_ORDER+1 items; a frame end waits while the previous bank drains
// reset: synchronous, clears pipeline valids, delay line, accumulators and output run
module frame_autocorrelation_unit #(
   parameter int PRED_ORDER  = fac_pkg::PRED_ORDER_DEF,
   parameter int MAX_FRAME   = fac_pkg::MAX_FRAME_DEF,
   parameter int SAMPLE_BITS = fac_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [SAMPLE_BITS-1:0]   req_sample,
   input  logic                            req_frame_end,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [fac_pkg::LAG_W-1:0]       rsp_lag,
   output logic signed [fac_pkg::SUM_W-1:0] rsp_corr_sum,
   output logic                            rsp_run_last
);
   import fac_pkg::*;

   localparam int ACC_W = $clog2(MAX_FRAME) + 2 * SAMPLE_BITS;

   ctl_type                         prod_ctl;
   logic signed [2*SAMPLE_BITS-1:0] prod [PRED_ORDER+1];
   logic signed [ACC_W-1:0]         sums [PRED_ORDER+1];
   logic                            adv;
   logic                            snap;
   logic                            bank_free;

   assign req_stall = !adv;

   // input register, delay line and lag products
   fac_front #(
      .PRED_ORDER  (PRED_ORDER),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .req_valid     (req_valid),
      .req_sample    (req_sample),
      .req_frame_end (req_frame_end),
      .prod_ctl      (prod_ctl),
      .prod          (prod)
   );

   // saturating lag accumulators
   fac_accum #(
      .PRED_ORDER  (PRED_ORDER),
      .MAX_FRAME   (MAX_FRAME),
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_W       (ACC_W)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .prod_ctl  (prod_ctl),
      .prod      (prod),
      .bank_free (bank_free),
      .adv       (adv),
      .snap      (snap),
      .sums      (sums)
   );

   // output bank, one sum per item in lag order
   fac_drain #(
      .PRED_ORDER (PRED_ORDER),
      .ACC_W      (ACC_W)
   ) u_drain (
      .clock        (clock),
      .reset        (reset),
      .snap         (snap),
      .sums         (sums),
      .bank_free    (bank_free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_lag      (rsp_lag),
      .rsp_corr_sum (rsp_corr_sum),
      .rsp_run_last (rsp_run_last)
   );

endmodule
